// File: hw/rtl/tidx_pkg.sv
// tidx_pkg: shared types, status codes and defaults for the trigger id extender
// no dependencies; imported by tidx_extend, trigger_id_extender_core and the testbench
`default_nettype none

package tidx_pkg;

    localparam int unsigned ID_BITS_DEF     = 15;
    localparam int unsigned CNT_W           = 15;
    localparam int unsigned TRIG_W          = 32;
    localparam int unsigned GAP_W           = 15;
    localparam logic [GAP_W-1:0] GAP_WINDOW_RST = 15'd200;

    typedef enum logic [1:0] {
        STATUS_IN_ORDER = 2'd0,
        STATUS_MISSED   = 2'd1,
        STATUS_BROKEN   = 2'd2
    } status_t;

    typedef struct packed {
        logic              forward;
        logic [TRIG_W-1:0] trigger_number;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/tidx_in_if.sv
// tidx_in_if: valid/ready channel carrying one frame counter per transaction
// depends on nothing
`default_nettype none

interface tidx_in_if;
    logic        valid;
    logic        ready;
    logic [14:0] frame_counter;

    modport source (output valid, output frame_counter, input ready);
    modport sink   (input valid, input frame_counter, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tidx_out_if.sv
// tidx_out_if: valid/ready channel carrying one extended trigger result per transaction
// depends on nothing
`default_nettype none

interface tidx_out_if;
    logic        valid;
    logic        ready;
    logic        forward;
    logic [31:0] trigger_number;
    logic [1:0]  status;

    modport source (output valid, output forward, output trigger_number, output status,
                    input ready);
    modport sink   (input valid, input forward, input trigger_number, input status,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tidx_extend.sv
// tidx_extend: expected-count state and the single-pass decision for one frame
// depends on tidx_pkg
`default_nettype none

module tidx_extend
    import tidx_pkg::*;
#(
    parameter int unsigned ID_BITS = ID_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [CNT_W-1:0] frame_counter,
    input  wire logic [GAP_W-1:0] gap_window,
    output result_t               result
);

    localparam logic [TRIG_W-1:0] LowMask = TRIG_W'((64'd1 << ID_BITS) - 64'd1);
    localparam logic [TRIG_W-1:0] Epoch   = TRIG_W'(64'd1 << ID_BITS);

    logic [TRIG_W-1:0] expected_reg;
    logic [TRIG_W-1:0] expected_next;
    logic              first_reg;

    logic [TRIG_W-1:0] low;
    logic [TRIG_W-1:0] exp_eff;
    logic [TRIG_W-1:0] base;
    logic [TRIG_W-1:0] cand_same;
    logic [TRIG_W-1:0] cand_next;
    logic [TRIG_W:0]   diff_same;
    logic [TRIG_W:0]   diff_next;
    logic [TRIG_W-1:0] gap_ext;
    logic              match;
    logic              ok_same;
    logic              ok_next;
    logic [TRIG_W-1:0] sel;

    assign low       = {{(TRIG_W-CNT_W){1'b0}}, frame_counter} & LowMask;
    assign exp_eff   = first_reg ? low : expected_reg;
    assign match     = (low == (exp_eff & LowMask));
    assign base      = exp_eff & ~LowMask;
    assign cand_same = base | low;
    assign cand_next = base + Epoch + low;
    assign gap_ext   = {{(TRIG_W-GAP_W){1'b0}}, gap_window};

    // a jump counts only if strictly ahead and closer than the gap window
    assign diff_same = {1'b0, cand_same} - {1'b0, exp_eff};
    assign diff_next = {1'b0, cand_next} - {1'b0, exp_eff};
    assign ok_same   = !diff_same[TRIG_W] && (diff_same[TRIG_W-1:0] != '0)
                       && (diff_same[TRIG_W-1:0] < gap_ext);
    assign ok_next   = !diff_next[TRIG_W] && (diff_next[TRIG_W-1:0] != '0)
                       && (diff_next[TRIG_W-1:0] < gap_ext);

    always_comb
    begin
        sel                   = exp_eff;
        result.forward        = 1'b1;
        result.status         = STATUS_IN_ORDER;
        if (!match)
        begin
            if (ok_same)
            begin
                sel           = cand_same;
                result.status = STATUS_MISSED;
            end
            else if (ok_next)
            begin
                sel           = cand_next;
                result.status = STATUS_MISSED;
            end
            else
            begin
                result.forward = 1'b0;
                result.status  = STATUS_BROKEN;
            end
        end
        result.trigger_number = result.forward ? (sel - TRIG_W'(1)) : '0;
        expected_next         = sel + TRIG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            first_reg    <= 1'b1;
        end
        else if (step)
        begin
            expected_reg <= expected_next;
            first_reg    <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/trigger_id_extender_core.sv
// trigger_id_extender_core: top level; input register, extend stage, result register
// depends on tidx_pkg, tidx_in_if, tidx_out_if, tidx_extend
//
// channel   | dir | handshake    | payload
// ----------+-----+--------------+------------------------------------------------
// in_chan   | in  | valid/ready  | frame_counter[14:0]
// out_chan  | out | valid/ready  | forward, trigger_number[31:0], status[1:0]
// cfg       | in  | cfg_we       | cfg_wdata[14:0] -> gap_window
//
// one transaction per cycle sustained while out_chan is not stalled
// frame_counter is registered, then decided, with the expected count updated as the result
// is loaded into the output register, where it is held until taken
// rst_n clears valids and expected count, sets first-frame flag; gap_window resets to 200
// a stalled output only blocks input once both the input and result registers are full
`default_nettype none

module trigger_id_extender_core
    import tidx_pkg::*;
#(
    parameter int unsigned ID_BITS = ID_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    tidx_in_if.sink               in_chan,
    tidx_out_if.source            out_chan,
    input  wire logic             cfg_we,
    input  wire logic [GAP_W-1:0] cfg_wdata
);

    // configuration
    logic [GAP_W-1:0] gap_window_reg;

    // input register
    logic             in_valid_reg;
    logic [CNT_W-1:0] cnt_reg;

    // result register
    logic             out_valid_reg;
    result_t          res_reg;
    result_t          res_next;

    logic             advance;
    logic             in_fire;

    // move an item from input register to result register when the result slot frees
    assign advance         = in_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready   = !in_valid_reg || advance;
    assign in_fire         = in_chan.valid && in_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_window_reg <= GAP_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            gap_window_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_valid_reg <= in_chan.valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cnt_reg <= in_chan.frame_counter;
        end
    end

    tidx_extend #(
        .ID_BITS (ID_BITS)
    ) u_extend (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .frame_counter (cnt_reg),
        .gap_window    (gap_window_reg),
        .result        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_chan.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_chan.valid          = out_valid_reg;
    assign out_chan.forward        = res_reg.forward;
    assign out_chan.trigger_number = res_reg.trigger_number;
    assign out_chan.status         = res_reg.status;

    // a decided item always shows up as a result on the next cycle
    a_advance_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decided item did not reach the result register");

    // forward is set exactly when the frame was not broken, dropped frames carry zero
    a_forward_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((res_reg.forward == (res_reg.status != STATUS_BROKEN))
                           && (res_reg.forward || (res_reg.trigger_number == '0))))
        else $error("forward flag and status disagree");

    // input only stalls when both stages hold an item and the output is stalled
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_chan.ready |-> (in_valid_reg && out_valid_reg && !out_chan.ready))
        else $error("input stalled with a free stage");

    // status code three never leaves the block
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.status == STATUS_IN_ORDER
                           || res_reg.status == STATUS_MISSED
                           || res_reg.status == STATUS_BROKEN))
        else $error("illegal status code");

endmodule

`default_nettype wire

// File: tb/tb_trigger_id_extender_core.sv
// tb_trigger_id_extender_core: self-checking bench for the trigger id extender
// predicts every extended trigger number and status from the frame counters sent in
// depends on tidx_pkg, tidx_in_if, tidx_out_if and trigger_id_extender_core
`timescale 1ns / 100ps

module tb_trigger_id_extender_core;
    import tidx_pkg::*;

    localparam logic [TRIG_W-1:0] LOW_MASK  = (32'd1 << ID_BITS_DEF) - 32'd1;
    localparam logic [TRIG_W-1:0] EPOCH     = 32'd1 << ID_BITS_DEF;
    localparam int unsigned MAX_IDLE        = 14;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned PHASE_FRAMES    = 210;
    localparam int unsigned IDLE_BLOCK      = 30;

    // holds the expected trigger count and the results still owed by the block
    class trigger_number_tracker;
        logic [GAP_W-1:0]  gap_window;
        logic [TRIG_W-1:0] next_trigger;
        bit                first_pending;
        result_t           pending_results[$];
        int unsigned       failures;

        function new();
            gap_window    = GAP_WINDOW_RST;
            next_trigger  = '0;
            first_pending = 1'b1;
            failures      = 0;
        endfunction

        function void note_fail(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        // a jump is taken only forward and strictly inside the gap window
        function bit jump_fits(logic [TRIG_W-1:0] candidate);
            logic [TRIG_W-1:0] distance;
            distance = candidate - next_trigger;
            return (candidate > next_trigger) && (distance < {17'd0, gap_window});
        endfunction

        function void note_frame(logic [CNT_W-1:0] counter);
            logic [TRIG_W-1:0] low;
            logic [TRIG_W-1:0] base;
            logic [TRIG_W-1:0] same_epoch;
            logic [TRIG_W-1:0] next_epoch;
            result_t           res;
            low = {17'd0, counter} & LOW_MASK;
            if (first_pending)
            begin
                first_pending = 1'b0;
                next_trigger  = low;
            end
            res.forward = 1'b1;
            res.status  = STATUS_IN_ORDER;
            if (low != (next_trigger & LOW_MASK))
            begin
                base       = next_trigger & ~LOW_MASK;
                same_epoch = base + low;
                next_epoch = base + EPOCH + low;
                // current epoch is tried first
                if (jump_fits(same_epoch))
                begin
                    next_trigger = same_epoch;
                    res.status   = STATUS_MISSED;
                end
                else if (jump_fits(next_epoch))
                begin
                    next_trigger = next_epoch;
                    res.status   = STATUS_MISSED;
                end
                else
                begin
                    res.forward = 1'b0;
                    res.status  = STATUS_BROKEN;
                end
            end
            // dropped frames report a zero number, the count moves on either way
            res.trigger_number = res.forward ? next_trigger - 32'd1 : '0;
            next_trigger       = next_trigger + 32'd1;
            pending_results.push_back(res);
        endfunction

        function void take_result(logic fwd, logic [TRIG_W-1:0] number, logic [1:0] st);
            result_t want;
            if (pending_results.size() == 0)
            begin
                note_fail($sformatf("unexpected result: fwd=%0d num=%08h st=%0d",
                                    fwd, number, st));
                return;
            end
            want = pending_results.pop_front();
            if (fwd !== want.forward || number !== want.trigger_number
                || st !== want.status)
                note_fail($sformatf({"mismatch: expected fwd=%0d num=%08h st=%0d,",
                                     " got fwd=%0d num=%08h st=%0d"},
                                    want.forward, want.trigger_number, want.status,
                                    fwd, number, st));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [GAP_W-1:0] cfg_wdata;

    tidx_in_if  in_chan();
    tidx_out_if out_chan();

    trigger_id_extender_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    trigger_number_tracker tracker = new();

    int unsigned in_idle_max  = 0;
    int unsigned out_idle_max = 0;
    int unsigned sink_wait    = 0;
    int unsigned cycle_count  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: take a transaction, then hold ready low for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_chan.valid && out_chan.ready)
        begin
            tracker.take_result(out_chan.forward, out_chan.trigger_number, out_chan.status);
            sink_wait = $urandom_range(out_idle_max, 0);
        end
        else if (sink_wait != 0)
            sink_wait--;
        out_chan.ready <= (rst_n === 1'b1) && (sink_wait == 0);
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // counter at a given distance from the next expected trigger number
    function automatic logic [CNT_W-1:0] cnt_at(int offset);
        logic [TRIG_W-1:0] value;
        value = tracker.next_trigger + 32'(offset);
        return value[CNT_W-1:0];
    endfunction

    // mostly well-formed streams: in order runs, accepted jumps, edge of window, noise
    function automatic logic [CNT_W-1:0] pick_counter();
        int unsigned roll;
        int          window;
        roll   = $urandom_range(99, 0);
        window = int'(tracker.gap_window);
        if (tracker.first_pending || roll < 15)
            return CNT_W'($urandom_range(32767, 0));
        if (roll < 60)
            return cnt_at(0);
        if (roll < 78 && window >= 2)
            return cnt_at(int'($urandom_range(window - 1, 1)));
        if (roll < 86)
            return cnt_at(window);
        if (roll < 94)
            return cnt_at(-int'($urandom_range(3, 1)));
        return cnt_at(int'($urandom_range(window + 50, window)));
    endfunction

    // valid stays high from one transaction to the next when no idle cycles are drawn
    task automatic send_frame(input logic [CNT_W-1:0] counter);
        int unsigned idle;
        idle = $urandom_range(in_idle_max, 0);
        if (idle != 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_chan.valid         <= 1'b1;
        in_chan.frame_counter <= counter;
        do
            @(posedge clk);
        while (!in_chan.ready);
        tracker.note_frame(counter);
    endtask

    task automatic wait_drained();
        in_chan.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.gap_window = value;
    endtask

    initial
    begin : stimulus
        logic [GAP_W-1:0] phase_gaps[6];
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        in_chan.valid         = 1'b0;
        in_chan.frame_counter = '0;
        out_chan.ready        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset gap window
        send_frame(15'd0);          // first frame at zero, number wraps to all ones
        send_frame(cnt_at(0));
        send_frame(15'h7fff);
        send_frame(cnt_at(199));    // largest jump inside the window
        send_frame(cnt_at(200));    // jump of exactly the window is broken
        send_frame(cnt_at(0));
        write_gap(15'h7fff);
        send_frame(cnt_at(-2));     // lands in the next epoch
        send_frame(cnt_at(-1));     // one short of a full epoch, broken
        send_frame(cnt_at(32766));
        send_frame(cnt_at(0));
        write_gap(15'd0);           // every mismatch is broken
        send_frame(cnt_at(1));
        send_frame(cnt_at(0));
        write_gap(15'd1);
        send_frame(cnt_at(1));
        write_gap(15'd2);
        send_frame(cnt_at(1));
        send_frame(cnt_at(0));

        // random phases, one gap window setting each
        phase_gaps[0] = GAP_WINDOW_RST;
        phase_gaps[1] = 15'h7fff;
        phase_gaps[2] = 15'd0;
        phase_gaps[3] = 15'd1;
        phase_gaps[4] = GAP_W'($urandom_range(400, 2));
        phase_gaps[5] = GAP_W'($urandom_range(32767, 1));
        foreach (phase_gaps[p])
        begin
            write_gap(phase_gaps[p]);
            for (int i = 0; i < PHASE_FRAMES; i++)
            begin
                if (i % IDLE_BLOCK == 0)
                begin
                    in_idle_max  = $urandom_range(1, 0) ? MAX_IDLE : 0;
                    out_idle_max = $urandom_range(1, 0) ? MAX_IDLE : 0;
                end
                send_frame(pick_counter());
            end
        end

        wait_drained();
        if (tracker.pending_results.size() != 0)
            tracker.note_fail("results still owed at end of run");
        if (tracker.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
